// ----- rtl/triangle_tangent_frame_defines.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef TRIANGLE_TANGENT_FRAME_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_DEFINES_SVH

// Plain property, sampled on clk, off while in reset.
`define TTF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication into the next cycle.
`define TTF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ttf_pkg.sv -----
`default_nettype none
package ttf_pkg;
	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LOAD,
		S_SHIFT,
		S_SQ,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_DIV_GO,
		S_DIV_WAIT,
		S_EMIT
	} state_t;

	localparam int MAG_BITS  = 31; // magnitude width after scaling
	localparam int SUM_BITS  = 64; // sum of squares
	localparam int ROOT_BITS = 32; // vector length
	localparam int NUM_PROD  = 14; // products for det, T and B
	localparam int NUM_SQ    = 3;  // squares per vector
	localparam logic [1:0] CORNER_LAST = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/triangle_tangent_frame.sv -----
// Vertices 0 and 1 of a triangle are stored as they are taken; the third starts
// the work for its three results, which includes a scaling shift of each vector.
// The shared multiplier, the bit-serial square root and divider do that work.
// Reset (arst_n low, async) clears the sequencer, slot count and valid flags;
// stored corners are undefined until written.
`default_nettype none
`include "triangle_tangent_frame_defines.svh"
module triangle_tangent_frame #(
	parameter int COORD_WIDTH    = 32,
	parameter int UNIT_FRAC_BITS = 14
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_z,
	input  wire logic signed [COORD_WIDTH-1:0]  tex_u,
	input  wire logic signed [COORD_WIDTH-1:0]  tex_v,
	input  wire logic                           last_vertex,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [UNIT_FRAC_BITS+1:0]    tangent_x,
	output logic signed [UNIT_FRAC_BITS+1:0]    tangent_y,
	output logic signed [UNIT_FRAC_BITS+1:0]    tangent_z,
	output logic signed [UNIT_FRAC_BITS+1:0]    bitangent_x,
	output logic signed [UNIT_FRAC_BITS+1:0]    bitangent_y,
	output logic signed [UNIT_FRAC_BITS+1:0]    bitangent_z,
	output logic        [1:0]                   corner,
	output logic                                degenerate,
	output logic                                triangle_done
);
	localparam int CW   = COORD_WIDTH;
	localparam int F    = UNIT_FRAC_BITS;
	localparam int DW   = CW + 1;             // edge / uv delta
	localparam int MULW = (DW > 32) ? DW : 32; // multiplier operand
	localparam int PW   = 2 * MULW;
	localparam int AW   = 2 * DW + 1;         // difference of two products
	localparam int OW   = F + 2;
	localparam int MB   = ttf_pkg::MAG_BITS;
	localparam int RB   = ttf_pkg::ROOT_BITS;

	ttf_pkg::state_t state_q, state_d;

	// stored corners 0 and 1
	logic        [1:0]     slot_q;
	logic signed [CW-1:0]  pos_q [2][3];
	logic signed [CW-1:0]  tex_q [2][2];

	// deltas of the current triangle
	logic signed [DW-1:0]  d1u_q, d1v_q, d2u_q, d2v_q;
	logic signed [DW-1:0]  e1_q [3];
	logic signed [DW-1:0]  e2_q [3];

	logic        [3:0]     step_q;
	logic        [1:0]     k_q;
	logic                  vsel_q;   // 0: tangent, 1: bitangent
	logic signed [AW-1:0]  acc_q;
	logic signed [AW-1:0]  det_q;
	logic signed [AW-1:0]  tw_q [3];
	logic signed [AW-1:0]  bw_q [3];
	logic        [AW-1:0]  mag_q [3];
	logic [ttf_pkg::SUM_BITS-1:0] sum_q;
	logic signed [OW-1:0]  tv_q [3];
	logic signed [OW-1:0]  bv_q [3];
	logic                  degen_q;
	logic        [1:0]     corner_q;

	logic                  in_acc, out_acc;
	logic signed [MULW-1:0] mul_a, mul_b;
	logic signed [PW-1:0]  mul_p;
	logic signed [AW-1:0]  prod;
	logic        [3:0]     pidx;
	logic        [1:0]     ki;
	logic signed [AW-1:0]  vec [3];
	logic        [AW-1:0]  mag_or;
	logic                  vec_zero;
	logic                  sqrt_start, sqrt_done, div_start, div_done;
	logic        [RB-1:0]  root;
	logic        [F:0]     quo;
	logic signed [OW-1:0]  qs;

	assign in_ready = (state_q == ttf_pkg::S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_valid = (state_q == ttf_pkg::S_EMIT);
	assign out_acc  = out_valid && out_ready;

	// ---------------- shared multiplier ----------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		pidx  = 4'd0;
		ki    = 2'd0;
		if (state_q == ttf_pkg::S_SQ) begin
			ki    = (step_q[1:0] == 2'd3) ? 2'd0 : step_q[1:0];
			mul_a = MULW'({1'b0, mag_q[ki][MB-1:0]});
			mul_b = mul_a;
		end else begin
			// 0,1: det; 2..7: T; 8..13: B (pairs per component)
			if (step_q >= 4'd8) pidx = step_q - 4'd8;
			else if (step_q >= 4'd2) pidx = step_q - 4'd2;
			ki = (pidx[2:1] == 2'd3) ? 2'd0 : pidx[2:1];
			priority if (step_q == 4'd0) begin
				mul_a = MULW'(d1u_q); mul_b = MULW'(d2v_q);
			end else if (step_q == 4'd1) begin
				mul_a = MULW'(d2u_q); mul_b = MULW'(d1v_q);
			end else if (step_q < 4'd8) begin
				mul_a = pidx[0] ? MULW'(d1v_q) : MULW'(d2v_q);
				mul_b = pidx[0] ? MULW'(e2_q[ki]) : MULW'(e1_q[ki]);
			end else begin
				mul_a = pidx[0] ? MULW'(d2u_q) : MULW'(d1u_q);
				mul_b = pidx[0] ? MULW'(e1_q[ki]) : MULW'(e2_q[ki]);
			end
		end
	end

	ttf_mul #(.W(MULW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign prod = AW'(mul_p);

	// ---------------- vector under normalization ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) vec[i] = vsel_q ? bw_q[i] : tw_q[i];
		vec_zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
		mag_or   = mag_q[0] | mag_q[1] | mag_q[2];
	end

	ttf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (root)
	);

	ttf_div #(.F(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag_q[k_q == 2'd3 ? 2'd0 : k_q][MB-1:0]),
		.len    (root),
		.done   (div_done),
		.quo    (quo)
	);

	// sign of the component, flipped for a negative determinant
	assign qs = (vec[k_q == 2'd3 ? 2'd0 : k_q][AW-1] != det_q[AW-1])
		? -OW'({1'b0, quo}) : OW'({1'b0, quo});

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ttf_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		unique case (state_q)
			ttf_pkg::S_IDLE:
				if (in_acc && slot_q == 2'd2) state_d = ttf_pkg::S_MUL;
			ttf_pkg::S_MUL:
				if (step_q == 4'(ttf_pkg::NUM_PROD)) state_d = ttf_pkg::S_LOAD;
			ttf_pkg::S_LOAD:
				if (det_q == '0 || vec_zero) state_d = ttf_pkg::S_EMIT;
				else state_d = ttf_pkg::S_SHIFT;
			ttf_pkg::S_SHIFT:
				if (mag_or[AW-1:MB] == '0) state_d = ttf_pkg::S_SQ;
			ttf_pkg::S_SQ:
				if (step_q == 4'(ttf_pkg::NUM_SQ)) state_d = ttf_pkg::S_SQRT_GO;
			ttf_pkg::S_SQRT_GO: begin
				sqrt_start = 1'b1;
				state_d    = ttf_pkg::S_SQRT_WAIT;
			end
			ttf_pkg::S_SQRT_WAIT:
				if (sqrt_done) state_d = ttf_pkg::S_DIV_GO;
			ttf_pkg::S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ttf_pkg::S_DIV_WAIT;
			end
			ttf_pkg::S_DIV_WAIT:
				if (div_done) begin
					if (k_q != 2'd2)  state_d = ttf_pkg::S_DIV_GO;
					else if (!vsel_q) state_d = ttf_pkg::S_LOAD;
					else              state_d = ttf_pkg::S_EMIT;
				end
			ttf_pkg::S_EMIT:
				if (out_acc && corner_q == ttf_pkg::CORNER_LAST) state_d = ttf_pkg::S_IDLE;
			default: state_d = ttf_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= 2'd0;
			step_q   <= 4'd0;
			k_q      <= 2'd0;
			vsel_q   <= 1'b0;
			corner_q <= 2'd0;
		end else begin
			unique case (state_q)
				ttf_pkg::S_IDLE: begin
					step_q   <= 4'd0;
					vsel_q   <= 1'b0;
					corner_q <= 2'd0;
					if (in_acc) begin
						if (slot_q == 2'd2 || last_vertex) slot_q <= 2'd0;
						else slot_q <= slot_q + 2'd1;
					end
				end
				ttf_pkg::S_MUL: step_q <= step_q + 4'd1;
				ttf_pkg::S_SHIFT: step_q <= 4'd0;
				ttf_pkg::S_SQ: step_q <= step_q + 4'd1;
				ttf_pkg::S_SQRT_WAIT: k_q <= 2'd0;
				ttf_pkg::S_DIV_WAIT:
					if (div_done) begin
						if (k_q != 2'd2) k_q <= k_q + 2'd1;
						else vsel_q <= 1'b1;
					end
				ttf_pkg::S_EMIT:
					if (out_acc) corner_q <= corner_q + 2'd1;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ttf_pkg::S_IDLE:
				if (in_acc) begin
					if (slot_q != 2'd2) begin
						pos_q[slot_q[0]][0] <= pos_x;
						pos_q[slot_q[0]][1] <= pos_y;
						pos_q[slot_q[0]][2] <= pos_z;
						tex_q[slot_q[0]][0] <= tex_u;
						tex_q[slot_q[0]][1] <= tex_v;
					end else begin
						e1_q[0] <= DW'(pos_q[1][0]) - DW'(pos_q[0][0]);
						e1_q[1] <= DW'(pos_q[1][1]) - DW'(pos_q[0][1]);
						e1_q[2] <= DW'(pos_q[1][2]) - DW'(pos_q[0][2]);
						e2_q[0] <= DW'(pos_x) - DW'(pos_q[0][0]);
						e2_q[1] <= DW'(pos_y) - DW'(pos_q[0][1]);
						e2_q[2] <= DW'(pos_z) - DW'(pos_q[0][2]);
						d1u_q   <= DW'(tex_q[1][0]) - DW'(tex_q[0][0]);
						d1v_q   <= DW'(tex_q[1][1]) - DW'(tex_q[0][1]);
						d2u_q   <= DW'(tex_u) - DW'(tex_q[0][0]);
						d2v_q   <= DW'(tex_v) - DW'(tex_q[0][1]);
					end
				end
			ttf_pkg::S_MUL:
				// product of step-1 is ready; odd steps load, even steps subtract
				if (step_q != 4'd0) begin
					if (step_q[0]) acc_q <= prod;
					else begin
						priority if (step_q == 4'd2) det_q <= acc_q - prod;
						else if (step_q <= 4'd8)
							tw_q[2'((step_q - 4'd4) >> 1)] <= acc_q - prod;
						else
							bw_q[2'((step_q - 4'd10) >> 1)] <= acc_q - prod;
					end
				end
			ttf_pkg::S_LOAD: begin
				degen_q <= (det_q == '0) || vec_zero;
				if (det_q == '0 || vec_zero) begin
					for (int i = 0; i < 3; i++) begin
						tv_q[i] <= '0;
						bv_q[i] <= '0;
					end
				end
				for (int i = 0; i < 3; i++)
					mag_q[i] <= vec[i][AW-1] ? AW'(-vec[i]) : AW'(vec[i]);
				sum_q <= '0;
			end
			ttf_pkg::S_SHIFT:
				if (mag_or[AW-1:MB] != '0)
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
			ttf_pkg::S_SQ:
				if (step_q != 4'd0) sum_q <= sum_q + mul_p[ttf_pkg::SUM_BITS-1:0];
			ttf_pkg::S_DIV_WAIT:
				if (div_done) begin
					if (vsel_q) bv_q[k_q == 2'd3 ? 2'd0 : k_q] <= qs;
					else        tv_q[k_q == 2'd3 ? 2'd0 : k_q] <= qs;
				end
			default: ;
		endcase
	end

	assign tangent_x     = tv_q[0];
	assign tangent_y     = tv_q[1];
	assign tangent_z     = tv_q[2];
	assign bitangent_x   = bv_q[0];
	assign bitangent_y   = bv_q[1];
	assign bitangent_z   = bv_q[2];
	assign corner        = corner_q;
	assign degenerate    = degen_q;
	assign triangle_done = (corner_q == ttf_pkg::CORNER_LAST);

	// ---------------- checks ----------------
	`TTF_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while results pending")
	`TTF_ASSERT_NEXT(a_back_idle, out_acc && triangle_done, in_ready, "no return to idle")
	`TTF_ASSERT(a_degen_zero, !(out_valid && degenerate) || (tangent_x == '0 && bitangent_z == '0),
		"degenerate result not zeroed")
	`TTF_ASSERT_NEXT(a_third_busy, in_acc && slot_q == 2'd2, !in_ready && slot_q == 2'd0,
		"third vertex did not start the triangle")
endmodule
`default_nettype wire

// ----- rtl/ttf_mul.sv -----
`default_nettype none
module ttf_mul #(
	parameter int W = 33
) (
	input  wire logic                  clk,
	input  wire logic signed [W-1:0]   a,
	input  wire logic signed [W-1:0]   b,
	output logic signed      [2*W-1:0] p
);
	// registered signed product
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
`default_nettype wire

// ----- rtl/ttf_sqrt.sv -----
`default_nettype none
module ttf_sqrt (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [ttf_pkg::SUM_BITS-1:0]   radicand,
	output logic                                done,
	output logic      [ttf_pkg::ROOT_BITS-1:0]  root
);
	localparam int RB = ttf_pkg::ROOT_BITS;
	localparam int SB = ttf_pkg::SUM_BITS;
	localparam int CNTW = $clog2(RB + 1);

	logic [SB-1:0]   x_q;
	logic [RB+1:0]   rem_q;
	logic [RB-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RB+1:0]   rem_sh;
	logic [RB+1:0]   trial;
	logic            ge;

	// one result bit per cycle, two radicand bits in
	always_comb begin
		rem_sh = {rem_q[RB-1:0], x_q[SB-1:SB-2]};
		trial  = {root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SB-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[RB-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ----- rtl/ttf_div.sv -----
`default_nettype none
module ttf_div #(
	parameter int F = 14
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [ttf_pkg::MAG_BITS-1:0]   mag,
	input  wire logic [ttf_pkg::ROOT_BITS-1:0]  len,
	output logic                                done,
	output logic      [F:0]                     quo
);
	localparam int MB = ttf_pkg::MAG_BITS;
	localparam int RB = ttf_pkg::ROOT_BITS;
	localparam int NW = MB + F + 1;
	localparam int CNTW = $clog2(F + 2);

	logic [NW-1:0]   num;
	logic [RB:0]     rem_q;
	logic [F:0]      lo_q;
	logic [RB-1:0]   d_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RB:0]     rs;
	logic            ge;

	// rounded numerator: mag * 2^F + len/2; quotient stays within F+1 bits
	assign num = {1'b0, mag, F'(0)} + NW'(len >> 1);

	always_comb begin
		rs = {rem_q[RB-1:0], lo_q[F]};
		ge = rs >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(F + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) busy_q <= 1'b0;
			end
		end
	end

	// low bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (RB+1)'(num >> (F + 1));
			lo_q  <= num[F:0];
			d_q   <= len;
		end else if (busy_q) begin
			rem_q <= ge ? rs - {1'b0, d_q} : rs;
			lo_q  <= {lo_q[F-1:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = lo_q;
endmodule
`default_nettype wire
